>>> rtl/ssd_pkg.sv
// Shared types, widths and constants for the separation steering block.
package ssd_pkg;

  localparam int MAX_AGENTS_DEF  = 256;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int POS_W  = 24;
  localparam int DIR_W  = 16;
  localparam int IDX_W  = 8;
  localparam int RAD_W  = 23;
  localparam int STR_W  = 16;
  localparam int SUM_W  = 40;
  localparam int D_W    = 25;
  localparam int D2_W   = 50;
  localparam int NRM_W  = 50;
  localparam int IN_W   = 152;
  localparam int OUT_W  = 48;
  localparam int ADDR_W = 3;

  localparam logic [D2_W-1:0]  NEAR_SQ_LIMIT  = 50'd16777;
  localparam logic [RAD_W-1:0] RADIUS_RESET   = 23'd8192;
  localparam logic [STR_W-1:0] STRENGTH_RESET = 16'd256;

  typedef enum logic {
    REG_RADIUS   = 1'b0,
    REG_STRENGTH = 1'b1
  } ssd_reg_e;

  // One classified neighbour word handed from the front to the back.
  typedef struct packed {
    logic                    hit;
    logic                    last;
    logic signed [D_W-1:0]   dx;
    logic signed [D_W-1:0]   dz;
    logic [D2_W-1:0]         d2;
    logic signed [DIR_W-1:0] want_x;
    logic signed [DIR_W-1:0] want_y;
    logic signed [DIR_W-1:0] want_z;
  } ssd_job_t;

endpackage

>>> rtl/ssd_isqrt.sv
// Iterative integer square root, one result bit per cycle.
module ssd_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] x;
  logic [33:0] rem;
  logic [4:0]  step;
  logic        run;
  logic [33:0] rem_sh;
  logic [33:0] trial;
  logic        ge;

  always_comb begin
    rem_sh = {rem[31:0], x[63:62]};
    trial  = {root, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= radicand;
        rem  <= '0;
        root <= '0;
        step <= '0;
        run  <= 1'b1;
      end else if (run) begin
        x    <= {x[61:0], 2'b00};
        rem  <= ge ? rem_sh - trial : rem_sh;
        root <= {root[30:0], ge};
        step <= step + 5'd1;
        if (step == 5'd31) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/ssd_div.sv
// Restoring divider for a 16-bit quotient, one quotient bit per cycle.
module ssd_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [47:0] den,
  output logic        done,
  output logic [15:0] quo
);

  logic [63:0] rem;
  logic [63:0] dsh;
  logic [3:0]  step;
  logic        run;
  logic        ge;

  assign ge = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= num;
        dsh  <= {1'b0, den, 15'd0};
        quo  <= '0;
        step <= '0;
        run  <= 1'b1;
      end else if (run) begin
        rem  <= ge ? rem - dsh : rem;
        dsh  <= {1'b0, dsh[63:1]};
        quo  <= {quo[14:0], ge};
        step <= step + 4'd1;
        if (step == 4'd15) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> rtl/ssd_front.sv
// Front end: accept neighbour words, square the offset and classify.
module ssd_front #(
  parameter int MAX_AGENTS = ssd_pkg::MAX_AGENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ssd_pkg::IN_W-1:0]      s_tdata,
  input  logic                          s_tlast,
  input  logic [ssd_pkg::RAD_W-1:0]     radius,
  input  logic                          full,
  output logic                          push,
  output ssd_pkg::ssd_job_t             job
);
  import ssd_pkg::*;

  localparam int CNT_W = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic [1:0] {F_IDLE, F_SQ, F_PUSH} state_t;

  state_t                   state;
  logic [CNT_W-1:0]         cnt;
  logic signed [POS_W-1:0]  sx, sz, ox, oz;
  logic signed [DIR_W-1:0]  wx, wy, wz;
  logic                     skip, last;
  logic signed [D_W-1:0]    dx, dz;
  logic [D2_W-1:0]          d2;
  logic [2*RAD_W-1:0]       r2;

  logic signed [D_W-1:0]    dx_c, dz_c;
  logic [D_W-1:0]           mdx, mdz;
  logic [D2_W-1:0]          sq_x, sq_z;
  logic [IDX_W-1:0]         own;

  assign own  = s_tdata[103:96];
  assign dx_c = {sx[POS_W-1], sx} - {ox[POS_W-1], ox};
  assign dz_c = {sz[POS_W-1], sz} - {oz[POS_W-1], oz};
  assign mdx  = dx_c[D_W-1] ? D_W'(-dx_c) : D_W'(dx_c);
  assign mdz  = dz_c[D_W-1] ? D_W'(-dz_c) : D_W'(dz_c);
  assign sq_x = {25'd0, mdx} * {25'd0, mdx};
  assign sq_z = {25'd0, mdz} * {25'd0, mdz};

  assign s_tready = (state == F_IDLE);
  assign push     = (state == F_PUSH) && !full;

  always_comb begin
    job.hit    = !skip && (radius != '0) && (d2 > NEAR_SQ_LIMIT) && (d2 < {4'd0, r2});
    job.last   = last;
    job.dx     = dx;
    job.dz     = dz;
    job.d2     = d2;
    job.want_x = wx;
    job.want_y = wy;
    job.want_z = wz;
  end

  always_ff @(posedge clk) begin
    r2 <= {23'd0, radius} * {23'd0, radius};
    if (rst) begin
      state <= F_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (s_tvalid) begin
            sx    <= s_tdata[23:0];
            sz    <= s_tdata[47:24];
            wx    <= s_tdata[63:48];
            wy    <= s_tdata[79:64];
            wz    <= s_tdata[95:80];
            ox    <= s_tdata[127:104];
            oz    <= s_tdata[151:128];
            last  <= s_tlast;
            skip  <= CMP_W'(cnt) == CMP_W'(own);
            if (s_tlast || cnt == CNT_W'(MAX_AGENTS - 1)) begin
              cnt <= '0;
            end else begin
              cnt <= cnt + 1'b1;
            end
            state <= F_SQ;
          end
        end
        F_SQ: begin
          dx    <= dx_c;
          dz    <= dz_c;
          d2    <= sq_x + sq_z;
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/ssd_fifo.sv
// Short queue of classified neighbour words between front and back.
module ssd_fifo #(
  parameter int DEPTH = ssd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ssd_pkg::ssd_job_t din,
  output logic              full,
  input  logic              pop,
  output ssd_pkg::ssd_job_t dout,
  output logic              empty
);
  import ssd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ssd_job_t        mem [DEPTH];
  logic [PW-1:0]   wp, rp;
  logic [CW-1:0]   count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/ssd_back.sv
// Back end: separation sums, blending and normalization of the result.
module ssd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  ssd_pkg::ssd_job_t             job,
  input  logic                          empty,
  output logic                          pop,
  input  logic [ssd_pkg::RAD_W-1:0]     radius,
  input  logic [ssd_pkg::STR_W-1:0]     strength,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ssd_pkg::OUT_W-1:0]     m_tdata
);
  import ssd_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE, B_DIST, B_PREP, B_DIVX, B_DIVZ, B_BMUL, B_BLEND,
    B_NLOAD, B_NSHIFT, B_NSQ, B_NROOT, B_NSQRT, B_NDIV, B_NEND
  } state_t;

  state_t                   state;
  ssd_job_t                 ent;
  logic signed [SUM_W-1:0]  sum_x, sum_z;
  logic [D_W-1:0]           distance;
  logic [63:0]              numz;
  logic [47:0]              den;
  logic signed [NRM_W-1:0]  cin [3];
  logic [NRM_W-1:0]         m [3];
  logic                     neg [3];
  logic signed [DIR_W-1:0]  o [3];
  logic signed [DIR_W-1:0]  des [3];
  logic [63:0]              ss;
  logic [1:0]               idx;
  logic                     phase;
  logic [47:0]              px, pz;

  logic                     sq_go, sq_done;
  logic [63:0]              sq_arg;
  logic [31:0]              sq_root;
  logic                     dv_go, dv_done;
  logic [63:0]              dv_num;
  logic [47:0]              dv_den;
  logic [15:0]              dv_q;

  logic [NRM_W-1:0]         mx;
  logic [D_W-1:0]           mdx, mdz;
  logic [RAD_W-1:0]         rd;
  logic [47:0]              prod_x, prod_z;
  logic [45:0]              den_c;
  logic [SUM_W-1:0]         msx, msz;
  logic [55:0]              psx, psz;
  logic signed [SUM_W-1:0]  term;
  logic signed [DIR_W-1:0]  oq;

  ssd_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(sq_go), .radicand(sq_arg),
    .done(sq_done), .root(sq_root)
  );

  ssd_div u_div (
    .clk(clk), .rst(rst), .start(dv_go), .num(dv_num), .den(dv_den),
    .done(dv_done), .quo(dv_q)
  );

  assign pop = (state == B_IDLE) && !empty;

  always_comb begin
    mx = (m[0] > m[1]) ? m[0] : m[1];
    if (m[2] > mx) begin
      mx = m[2];
    end
    mdx    = ent.dx[D_W-1] ? D_W'(-ent.dx) : D_W'(ent.dx);
    mdz    = ent.dz[D_W-1] ? D_W'(-ent.dz) : D_W'(ent.dz);
    rd     = radius - distance[RAD_W-1:0];
    prod_x = {23'd0, mdx} * {25'd0, rd};
    prod_z = {23'd0, mdz} * {25'd0, rd};
    den_c  = {23'd0, distance[RAD_W-1:0]} * {23'd0, radius};
    msx    = sum_x[SUM_W-1] ? SUM_W'(-sum_x) : SUM_W'(sum_x);
    msz    = sum_z[SUM_W-1] ? SUM_W'(-sum_z) : SUM_W'(sum_z);
    psx    = {16'd0, msx} * {40'd0, strength};
    psz    = {16'd0, msz} * {40'd0, strength};
    term   = {{(SUM_W-16){1'b0}}, dv_q};
    oq     = neg[idx] ? DIR_W'(-dv_q) : DIR_W'(dv_q);
  end

  always_ff @(posedge clk) begin
    sq_go <= 1'b0;
    dv_go <= 1'b0;
    if (rst) begin
      state    <= B_IDLE;
      sum_x    <= '0;
      sum_z    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // drop the result once it is taken
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!empty) begin
            ent <= job;
            if (job.hit) begin
              sq_go  <= 1'b1;
              sq_arg <= {14'd0, job.d2};
              state  <= B_DIST;
            end else if (job.last) begin
              cin[0] <= NRM_W'(job.want_x);
              cin[1] <= NRM_W'(job.want_y);
              cin[2] <= NRM_W'(job.want_z);
              phase  <= 1'b0;
              state  <= B_NLOAD;
            end
          end
        end
        B_DIST: begin
          if (sq_done) begin
            distance <= sq_root[D_W-1:0];
            state    <= B_PREP;
          end
        end
        B_PREP: begin
          numz   <= {2'd0, prod_z, 14'd0};
          den    <= {2'd0, den_c};
          dv_go  <= 1'b1;
          dv_num <= {2'd0, prod_x, 14'd0};
          dv_den <= {2'd0, den_c};
          state  <= B_DIVX;
        end
        B_DIVX: begin
          if (dv_done) begin
            sum_x  <= ent.dx[D_W-1] ? sum_x - term : sum_x + term;
            dv_go  <= 1'b1;
            dv_num <= numz;
            dv_den <= den;
            state  <= B_DIVZ;
          end
        end
        B_DIVZ: begin
          if (dv_done) begin
            sum_z <= ent.dz[D_W-1] ? sum_z - term : sum_z + term;
            if (ent.last) begin
              cin[0] <= NRM_W'(ent.want_x);
              cin[1] <= NRM_W'(ent.want_y);
              cin[2] <= NRM_W'(ent.want_z);
              phase  <= 1'b0;
              state  <= B_NLOAD;
            end else begin
              state <= B_IDLE;
            end
          end
        end
        B_BMUL: begin
          px    <= psx[55:8];
          pz    <= psz[55:8];
          state <= B_BLEND;
        end
        B_BLEND: begin
          cin[0] <= NRM_W'(des[0]) + (sum_x[SUM_W-1] ? -NRM_W'(px) : NRM_W'(px));
          cin[1] <= NRM_W'(des[1]);
          cin[2] <= NRM_W'(des[2]) + (sum_z[SUM_W-1] ? -NRM_W'(pz) : NRM_W'(pz));
          phase  <= 1'b1;
          state  <= B_NLOAD;
        end
        B_NLOAD: begin
          for (int i = 0; i < 3; i++) begin
            neg[i] <= cin[i][NRM_W-1];
            m[i]   <= cin[i][NRM_W-1] ? NRM_W'(-cin[i]) : NRM_W'(cin[i]);
          end
          state <= B_NSHIFT;
        end
        B_NSHIFT: begin
          // walk the largest magnitude into [2^29, 2^30)
          if (mx == '0) begin
            for (int i = 0; i < 3; i++) begin
              o[i] <= '0;
            end
            state <= B_NEND;
          end else if (mx[NRM_W-1:30] != '0) begin
            for (int i = 0; i < 3; i++) begin
              m[i] <= {1'b0, m[i][NRM_W-1:1]};
            end
          end else if (!mx[29]) begin
            for (int i = 0; i < 3; i++) begin
              m[i] <= {m[i][NRM_W-2:0], 1'b0};
            end
          end else begin
            ss    <= '0;
            idx   <= '0;
            state <= B_NSQ;
          end
        end
        B_NSQ: begin
          ss  <= ss + {34'd0, m[idx][29:0]} * {34'd0, m[idx][29:0]};
          idx <= idx + 2'd1;
          if (idx == 2'd2) begin
            state <= B_NROOT;
          end
        end
        B_NROOT: begin
          sq_go  <= 1'b1;
          sq_arg <= ss;
          state  <= B_NSQRT;
        end
        B_NSQRT: begin
          if (sq_done) begin
            idx    <= '0;
            dv_go  <= 1'b1;
            dv_num <= {20'd0, m[0][29:0], 14'd0};
            dv_den <= {16'd0, sq_root};
            den    <= {16'd0, sq_root};
            state  <= B_NDIV;
          end
        end
        B_NDIV: begin
          if (dv_done) begin
            o[idx] <= oq;
            if (idx == 2'd2) begin
              state <= B_NEND;
            end else begin
              idx    <= idx + 2'd1;
              dv_go  <= 1'b1;
              dv_num <= {20'd0, m[idx + 2'd1][29:0], 14'd0};
              dv_den <= den;
            end
          end
        end
        B_NEND: begin
          if (!phase) begin
            des[0] <= o[0];
            des[1] <= o[1];
            des[2] <= o[2];
            state  <= B_BMUL;
          end else if (!m_tvalid || m_tready) begin
            if (o[0] == '0 && o[1] == '0 && o[2] == '0) begin
              m_tdata <= {des[2], des[1], des[0]};
            end else begin
              m_tdata <= {o[2], o[1], o[0]};
            end
            m_tvalid <= 1'b1;
            sum_x    <= '0;
            sum_z    <= '0;
            state    <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/separation_steering_direction.sv
// Flow: the front takes one word at a time and holds s_tready low until it has pushed
// it; the back drops a skipped neighbour and spends a 32-step square root and two
// 16-step divides on a counted one. The last word adds two normalizations, and a zero
// vector skips the root and divides; the shared root and divide units set the time a
// result takes after its last word is accepted.
// Reset (rst, synchronous) clears the sums, run position, queue and handshake state,
// and loads radius 2.0 and strength 1.0.
module separation_steering_direction #(
  parameter int MAX_AGENTS  = ssd_pkg::MAX_AGENTS_DEF,
  parameter int QUEUE_DEPTH = ssd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // APB-style register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssd_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // self_x, self_z, want_x, want_y, want_z, own_index, other_x, other_z
  input  logic [ssd_pkg::IN_W-1:0]    s_tdata,
  input  logic                        s_tlast,
  // output stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // dir_x, dir_y, dir_z
  output logic [ssd_pkg::OUT_W-1:0]   m_tdata
);
  import ssd_pkg::*;

  logic [RAD_W-1:0] radius;
  logic [STR_W-1:0] strength;
  ssd_job_t         f_job, b_job;
  logic             q_push, q_pop, q_full, q_empty;

  // Registers sit at byte address 0 (radius) and 4 (strength); bit 2 picks one.
  assign pready = 1'b1;

  always_comb begin
    unique case (ssd_reg_e'(paddr[2]))
      REG_RADIUS:   prdata = {9'd0, radius};
      REG_STRENGTH: prdata = {16'd0, strength};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius   <= RADIUS_RESET;
      strength <= STRENGTH_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (ssd_reg_e'(paddr[2]))
        REG_RADIUS:   radius   <= pwdata[RAD_W-1:0];
        REG_STRENGTH: strength <= pwdata[STR_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: accept a word, track the run position, square the offset, classify.
  ssd_front #(.MAX_AGENTS(MAX_AGENTS)) u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .radius(radius), .full(q_full), .push(q_push), .job(f_job)
  );

  // Queue lets the front keep taking words while the back grinds on one.
  ssd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk(clk), .rst(rst),
    .push(q_push), .din(f_job), .full(q_full),
    .pop(q_pop), .dout(b_job), .empty(q_empty)
  );

  // Back: accumulate the push terms, blend, normalize and hold the result word.
  ssd_back u_back (
    .clk(clk), .rst(rst),
    .job(b_job), .empty(q_empty), .pop(q_pop),
    .radius(radius), .strength(strength),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

endmodule

>>> test/separation_steering_direction_test.sv
// Self-checking testbench for the separation steering direction block.
`timescale 1ns / 100ps

// Expected-direction store: mirrors the block's run state and predicts each result.
class steer_board;
  bit [22:0] radius;
  bit [15:0] strength;
  logic signed [39:0] sum_x, sum_z;
  int unsigned run_pos;
  logic [47:0] dir_q[$];
  int errors;

  function new();
    radius = 23'd8192;
    strength = 16'd256;
    sum_x = 0;
    sum_z = 0;
    run_pos = 0;
    errors = 0;
  endfunction

  static function longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  static function longint unsigned absval(longint v);
    return v < 0 ? 64'd0 - longint'(v) : longint'(v);
  endfunction

  // Scale to unit length in Q2.14; zero stays zero.
  static function void unit3(input longint c[3], output longint o[3]);
    longint unsigned m[3], mx, ss, len;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = absval(c[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return;
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    ss = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = root64(ss);
    for (int i = 0; i < 3; i++) begin
      o[i] = longint'((m[i] << 14) / len);
      if (c[i] < 0) o[i] = -o[i];
    end
  endfunction

  static function longint push_term(longint d, longint unsigned distance,
                                    longint unsigned r);
    longint unsigned q;
    q = ((absval(d) * (r - distance)) << 14) / (distance * r);
    return d < 0 ? -longint'(q) : longint'(q);
  endfunction

  static function longint gain(logic signed [39:0] s, bit [15:0] g);
    longint unsigned q;
    q = (absval(longint'(s)) * g) >> 8;
    return s < 0 ? -longint'(q) : longint'(q);
  endfunction

  // Note one accepted neighbour word.
  function void note_word(logic [151:0] d, bit last);
    longint sx, sz, ox, oz, dx, dz;
    longint unsigned d2, distance, r;
    longint want[3], des[3], blend[3], res[3];
    sx = longint'($signed(d[23:0]));
    sz = longint'($signed(d[47:24]));
    ox = longint'($signed(d[127:104]));
    oz = longint'($signed(d[151:128]));
    r = radius;
    if (run_pos != d[103:96] && r != 0) begin
      dx = sx - ox;
      dz = sz - oz;
      d2 = absval(dx) * absval(dx) + absval(dz) * absval(dz);
      if (d2 > 64'd16777 && d2 < r * r) begin
        distance = root64(d2);
        sum_x = sum_x + 40'(push_term(dx, distance, r));
        sum_z = sum_z + 40'(push_term(dz, distance, r));
      end
    end
    run_pos = (run_pos + 1) % 256;
    if (!last) return;
    want[0] = longint'($signed(d[63:48]));
    want[1] = longint'($signed(d[79:64]));
    want[2] = longint'($signed(d[95:80]));
    unit3(want, des);
    blend[0] = des[0] + gain(sum_x, strength);
    blend[1] = des[1];
    blend[2] = des[2] + gain(sum_z, strength);
    unit3(blend, res);
    if (res[0] == 0 && res[1] == 0 && res[2] == 0) res = des;
    dir_q.push_back({res[2][15:0], res[1][15:0], res[0][15:0]});
    sum_x = 0;
    sum_z = 0;
    run_pos = 0;
  endfunction

  // Compare one accepted direction word with the oldest prediction.
  function void check_dir(logic [47:0] got);
    logic [47:0] exp_w;
    if (dir_q.size() == 0) begin
      $display("%0t: unexpected direction word %h", $time, got);
      errors++;
      return;
    end
    exp_w = dir_q.pop_front();
    for (int i = 0; i < 3; i++)
      if (got[16*i +: 16] !== exp_w[16*i +: 16]) begin
        $display("%0t: dir component %0d expected %h actual %h", $time, i,
                 exp_w[16*i +: 16], got[16*i +: 16]);
        errors++;
      end
  endfunction
endclass

module separation_steering_direction_test;
  import ssd_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_tvalid = 0;
  logic s_tready;
  // self_x, self_z, want_x, want_y, want_z, own_index, other_x, other_z
  logic [IN_W-1:0] s_tdata = '0;
  logic s_tlast = 0;
  logic m_tvalid;
  logic m_tready = 0;
  // dir_x, dir_y, dir_z
  logic [OUT_W-1:0] m_tdata;

  steer_board board = new();
  longint unsigned cycles = 0;
  bit hold_sink = 0;

  separation_steering_direction dut (.*);

  always #4 clk = ~clk;

  // Guard the run against a hang.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Sink: random stalls, mostly short; a long hold-off while hold_sink is set.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_dir(m_tdata);
    if (rst || hold_sink) m_tready <= 0;
    else if ($urandom_range(0, 99) < 8) m_tready <= 0;
    else if ($urandom_range(0, 99) < 3) m_tready <= 0;
    else m_tready <= 1;
  end

  task automatic reg_write(ssd_reg_e idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= ADDR_W'({idx, 2'b00}); pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (idx == REG_RADIUS) board.radius = val[22:0];
    else board.strength = val[15:0];
  endtask

  // Offer one word and hold it until accepted; idle before it at random.
  // Valid stays high after acceptance until the next word or drain() drops it.
  task automatic send_word(logic [IN_W-1:0] d, bit last);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1; s_tdata <= d; s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_word(d, last);
  endtask

  function automatic logic [IN_W-1:0] pack_word(logic [23:0] sx, logic [23:0] sz,
      logic [15:0] wx, logic [15:0] wy, logic [15:0] wz, logic [7:0] own,
      logic [23:0] ox, logic [23:0] oz);
    return {16'h0, oz, ox, own, wz, wy, wx, sz, sx};
  endfunction

  // One query run with neighbors scattered around self at a chosen spread.
  task automatic send_run(int len, int spread);
    logic [23:0] sx, sz, ox, oz;
    logic [15:0] wx, wy, wz;
    logic [7:0] own;
    sx = $urandom; sz = $urandom;
    if ($urandom_range(0, 2) != 0) begin
      sx = 24'($signed(sx) >>> 4);
      sz = 24'($signed(sz) >>> 4);
    end
    wx = $urandom; wy = $urandom; wz = $urandom;
    if ($urandom_range(0, 15) == 0) {wx, wy, wz} = '0;
    own = $urandom_range(0, len);
    for (int i = 0; i < len; i++) begin
      ox = sx + 24'($signed($urandom_range(0, 2 * spread)) - spread);
      oz = sz + 24'($signed($urandom_range(0, 2 * spread)) - spread);
      if ($urandom_range(0, 19) == 0) begin ox = $urandom; oz = $urandom; end
      if ($urandom_range(0, 9) == 0) begin ox = sx; oz = sz; end
      send_word(pack_word(sx, sz, wx, wy, wz, own, ox, oz), i == len - 1);
    end
  endtask

  // Drop valid, wait for every predicted word, then let a stray run finish.
  task automatic drain();
    s_tvalid <= 0;
    while (board.dir_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  initial begin
    int spread;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes, self skip, coincident and near neighbors, zero vectors.
    send_word(pack_word(24'h7FFFFF, 24'h800000, 16'h7FFF, 16'h8000, 16'h7FFF, 8'd0,
                        24'h800000, 24'h7FFFFF), 1);
    send_word(pack_word(0, 0, 0, 0, 0, 8'd0, 0, 0), 1);
    send_word(pack_word(0, 0, 16'h4000, 0, 0, 8'd1, 24'd4096, 0), 0);
    send_word(pack_word(0, 0, 16'h4000, 0, 0, 8'd1, 24'd100, 24'd50), 0);
    send_word(pack_word(0, 0, 16'h4000, 0, 0, 8'd1, 24'd2000, 24'hFFF000), 1);
    // Push opposite the desired direction at half its length, so the blend shrinks it but does not cancel.
    send_word(pack_word(0, 0, 16'hC000, 0, 0, 8'd5, 24'hFFF000, 0), 1);
    send_word(pack_word(24'h000800, 0, 0, 16'h7FFF, 0, 8'd9, 0, 24'h001000), 1);
    drain();
    reg_write(REG_RADIUS, 0);
    reg_write(REG_STRENGTH, 32'hFFFF);
    send_word(pack_word(0, 0, 16'h1234, 16'h8000, 16'h0FFF, 8'd3, 24'd10, 24'd10), 1);
    send_word(pack_word(0, 0, 0, 0, 0, 8'd3, 24'd100, 24'd10), 1);
    drain();
    reg_write(REG_RADIUS, 32'h7FFFFF);
    reg_write(REG_STRENGTH, 0);
    send_run(3, 1 << 22);
    drain();
    reg_write(REG_STRENGTH, 32'hFFFF);
    send_run(4, 1 << 23);
    // Long run wraps the run position.
    send_run(260, 1 << 20);
    drain();

    // Random phases across several register settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin reg_write(REG_RADIUS, 8192); reg_write(REG_STRENGTH, 256); end
        1: begin reg_write(REG_RADIUS, 1); reg_write(REG_STRENGTH, 1); end
        2: begin reg_write(REG_RADIUS, 32'h7FFFFF); reg_write(REG_STRENGTH, 32'hFFFF); end
        default: begin
          reg_write(REG_RADIUS, $urandom_range(0, 23'h7FFFFF) >> $urandom_range(0, 14));
          reg_write(REG_STRENGTH, $urandom_range(0, 16'hFFFF));
        end
      endcase
      if (ph == 1) begin
        // Hold the sink off while short runs keep coming, so the block backs up.
        hold_sink = 1;
        fork
          begin repeat (3000) @(posedge clk); hold_sink = 0; end
          for (int k = 0; k < 12; k++) send_run($urandom_range(1, 2), 64);
        join
      end
      for (int n = 0; n < 230; ) begin
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
        spread = (board.radius == 0) ? 16384 : int'(board.radius) + 200;
        if (spread > (1 << 22)) spread = 1 << 22;
        send_run(len, spread);
        n += len;
      end
      drain();
    end

    if (board.errors == 0 && board.dir_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule

>>> filelist.f
rtl/ssd_pkg.sv
rtl/ssd_isqrt.sv
rtl/ssd_div.sv
rtl/ssd_front.sv
rtl/ssd_fifo.sv
rtl/ssd_back.sv
rtl/separation_steering_direction.sv
test/separation_steering_direction_test.sv
